@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the three-wire serial master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("same-cycle check failed");

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

@@ rtl/rtc3w_pkg.sv @@
// Shared types, codes and helpers for the three-wire serial master.
package rtc3w_pkg;

    localparam int TickWidth = 16;
    localparam int AddrWidth = 4;
    localparam int DataWidth = 32;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] RegHalfPeriod  = 2'd0;
    localparam logic [1:0] RegEnableSetup = 2'd1;
    localparam logic [1:0] RegEnableHold  = 2'd2;

    localparam logic [TickWidth-1:0] TickReset = 16'd5;

    // Command codes carried by each tick.
    localparam logic [1:0] CmdTick  = 2'd0;
    localparam logic [1:0] CmdWrite = 2'd1;
    localparam logic [1:0] CmdRead  = 2'd2;

    // Address bits come first, then eight data bits.
    localparam logic [4:0] AddrBits  = 5'd8;
    localparam logic [4:0] TotalBits = 5'd16;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_LOW   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_HOLD  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [TickWidth-1:0] half_period_ticks;
        logic [TickWidth-1:0] enable_setup_ticks;
        logic [TickWidth-1:0] enable_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_pin_out;
        logic       data_pin_drive;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
    } t_result;

    // A programmed tick count of zero behaves as one.
    function automatic logic [TickWidth-1:0] at_least_one(input logic [TickWidth-1:0] v);
        return (v == '0) ? {{(TickWidth-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

@@ rtl/rtc3w_cfg_regs.sv @@
// APB configuration registers holding the bit and chip-enable timing.
module rtc3w_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtc3w_pkg::AddrWidth-1:0]  paddr,
    input  logic [rtc3w_pkg::DataWidth-1:0]  pwdata,
    output logic [rtc3w_pkg::DataWidth-1:0]  prdata,
    output logic                             pready,
    output rtc3w_pkg::t_cfg                  o_cfg
);
    import rtc3w_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (paddr[3:2])
                RegHalfPeriod:  n_cfg.half_period_ticks  = pwdata[TickWidth-1:0];
                RegEnableSetup: n_cfg.enable_setup_ticks = pwdata[TickWidth-1:0];
                RegEnableHold:  n_cfg.enable_hold_ticks  = pwdata[TickWidth-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks  <= TickReset;
            r_cfg.enable_setup_ticks <= TickReset;
            r_cfg.enable_hold_ticks  <= TickReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegHalfPeriod:  prdata = {{(DataWidth-TickWidth){1'b0}}, r_cfg.half_period_ticks};
            RegEnableSetup: prdata = {{(DataWidth-TickWidth){1'b0}}, r_cfg.enable_setup_ticks};
            RegEnableHold:  prdata = {{(DataWidth-TickWidth){1'b0}}, r_cfg.enable_hold_ticks};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/rtc3w_seq.sv @@
// Pin sequencer: advances the transfer by one tick per step and forms the pin levels.
module rtc3w_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtc3w_pkg::t_cfg   i_cfg,
    input  logic              i_step,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_reg_address,
    input  logic [7:0]        i_write_byte,
    input  logic              i_data_pin_in,
    output rtc3w_pkg::t_result o_result
);
    import rtc3w_pkg::*;

    t_phase               r_phase,       n_phase;
    logic [4:0]           r_bit_counter, n_bit_counter;
    logic [TickWidth-1:0] r_tick_timer,  n_tick_timer;
    logic [15:0]          r_out_shift,   n_out_shift;
    logic [7:0]           r_in_shift,    n_in_shift;
    logic                 r_reading,     n_reading;
    logic [7:0]           r_held_read,   n_held_read;

    logic                 w_start;
    logic                 w_read_bit;
    logic [TickWidth-1:0] w_timer_dec;
    logic [TickWidth-1:0] w_setup_left;
    logic [4:0]           w_bit_inc;

    assign w_start      = (i_command == CmdWrite) || (i_command == CmdRead);
    assign w_read_bit   = r_reading && (r_bit_counter >= AddrBits);
    assign w_timer_dec  = (r_tick_timer == '0) ? '0 : r_tick_timer - 1'b1;
    // The start tick already counts toward the setup time.
    assign w_setup_left = at_least_one(i_cfg.enable_setup_ticks) - 1'b1;
    assign w_bit_inc    = r_bit_counter + 1'b1;

    // Next state.
    always_comb begin
        n_phase       = r_phase;
        n_bit_counter = r_bit_counter;
        n_tick_timer  = r_tick_timer;
        n_out_shift   = r_out_shift;
        n_in_shift    = r_in_shift;
        n_reading     = r_reading;
        n_held_read   = r_held_read;
        unique case (r_phase)
            PH_SETUP: begin
                n_tick_timer = w_timer_dec;
                if (w_timer_dec == '0) begin
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (w_read_bit) begin
                    n_in_shift = {i_data_pin_in, r_in_shift[7:1]};
                end
                n_phase      = PH_HIGH;
                n_tick_timer = at_least_one(i_cfg.half_period_ticks);
            end
            PH_HIGH: begin
                n_tick_timer = w_timer_dec;
                if (w_timer_dec == '0) begin
                    n_out_shift   = {1'b0, r_out_shift[15:1]};
                    n_bit_counter = w_bit_inc;
                    if (w_bit_inc >= TotalBits) begin
                        n_phase      = PH_HOLD;
                        n_tick_timer = at_least_one(i_cfg.enable_hold_ticks);
                    end else begin
                        n_phase = PH_LOW;
                    end
                end
            end
            PH_HOLD: begin
                n_tick_timer = w_timer_dec;
                if (w_timer_dec == '0) begin
                    if (r_reading) begin
                        n_held_read = r_in_shift;
                    end
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_start) begin
                    n_reading     = (i_command == CmdRead);
                    n_out_shift   = (i_command == CmdRead) ? {8'h00, i_reg_address}
                                                           : {i_write_byte, i_reg_address};
                    n_in_shift    = '0;
                    n_bit_counter = '0;
                    n_tick_timer  = w_setup_left;
                    n_phase       = (w_setup_left == '0) ? PH_LOW : PH_SETUP;
                end
            end
        endcase
    end

    // Pin levels and status for this tick.
    always_comb begin
        o_result                = '0;
        o_result.data_pin_drive = 1'b1;
        o_result.read_byte      = n_held_read;
        unique case (r_phase) inside
            PH_SETUP: begin
                o_result.chip_enable = 1'b1;
                o_result.busy        = 1'b1;
            end
            PH_LOW, PH_HIGH: begin
                o_result.chip_enable    = 1'b1;
                o_result.busy           = 1'b1;
                o_result.serial_clock   = (r_phase == PH_HIGH);
                o_result.data_pin_drive = !w_read_bit;
                o_result.data_pin_out   = !w_read_bit && r_out_shift[0];
            end
            PH_HOLD: begin
                o_result.busy = (w_timer_dec != '0);
                o_result.done = (w_timer_dec == '0);
            end
            default: begin
                o_result.chip_enable = w_start;
                o_result.busy        = w_start;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_counter <= '0;
            r_tick_timer  <= '0;
            r_out_shift   <= '0;
            r_in_shift    <= '0;
            r_reading     <= 1'b0;
            r_held_read   <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_counter <= n_bit_counter;
            r_tick_timer  <= n_tick_timer;
            r_out_shift   <= n_out_shift;
            r_in_shift    <= n_in_shift;
            r_reading     <= n_reading;
            r_held_read   <= n_held_read;
        end
    end

endmodule

@@ rtl/three_wire_rtc_serial_master.sv @@
// Top level of the three-wire serial master for a clock chip.
//
// Each transfer on the input channel is one timebase tick: a command (tick
// only, start write, start read), the address and write byte taken at start,
// and the sampled level of the data pin. Each input transfer yields exactly
// one output transfer with the pin levels for that tick, busy, a done pulse
// and the byte of the last read.
// An input transfer lands in an input register and is then processed
// straight into the result register, which offers the result on the result
// channel. One tick is accepted every cycle while the receiver does not
// stall; the sequencer state is the only thing carried from tick to tick.
// When the receiver stalls, the result register holds and the input register
// holds its tick, and o_in_stall rises until the result is taken.
// Reset returns the sequencer to idle with read_byte zero and sets all three
// timing registers to five ticks. The user must write the timing registers
// over the APB port only while no transfer is in progress; the block does not enforce it.
`include "assert_macros.svh"

module three_wire_rtc_serial_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtc3w_pkg::AddrWidth-1:0]  paddr,
    input  logic [rtc3w_pkg::DataWidth-1:0]  pwdata,
    output logic [rtc3w_pkg::DataWidth-1:0]  prdata,
    output logic                             pready,
    // Tick input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [7:0]                       i_reg_address,
    input  logic [7:0]                       i_write_byte,
    input  logic                             i_data_pin_in,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_chip_enable,
    output logic                             o_serial_clock,
    output logic                             o_data_pin_out,
    output logic                             o_data_pin_drive,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [7:0]                       o_read_byte
);
    import rtc3w_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_res;

    logic       r_in_valid;
    logic [1:0] r_command;
    logic [7:0] r_reg_address;
    logic [7:0] r_write_byte;
    logic       r_data_pin_in;
    logic       r_out_valid;
    logic       w_in_accept;
    logic       w_advance;

    rtc3w_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held tick moves on whenever the result register is empty or being taken.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_command     <= i_command;
            r_reg_address <= i_reg_address;
            r_write_byte  <= i_write_byte;
            r_data_pin_in <= i_data_pin_in;
        end
    end

    rtc3w_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_step        (w_advance),
        .i_command     (r_command),
        .i_reg_address (r_reg_address),
        .i_write_byte  (r_write_byte),
        .i_data_pin_in (r_data_pin_in),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chip_enable    = r_res.chip_enable;
    assign o_serial_clock   = r_res.serial_clock;
    assign o_data_pin_out   = r_res.data_pin_out;
    assign o_data_pin_drive = r_res.data_pin_drive;
    assign o_busy_res       = r_res.busy;
    assign o_done_res       = r_res.done;
    assign o_read_byte      = r_res.read_byte;

    `ASSERT_SAME(a_done_ends_transfer, r_out_valid && r_res.done,
                 !r_res.busy && !r_res.chip_enable)
    `ASSERT_SAME(a_released_pin_low, r_out_valid && !r_res.data_pin_drive,
                 !r_res.data_pin_out && r_res.chip_enable)
    `ASSERT_SAME(a_clock_inside_enable, r_out_valid && r_res.serial_clock,
                 r_res.chip_enable && r_res.busy)
    `ASSERT_NEXT(a_blocked_tick_kept, r_in_valid && !w_advance, r_in_valid)

endmodule
